[rtl/csrmv_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and sizes for the CSR sparse matrix-vector multiplier.
// No dependencies; imported by csrmv_ram and the top level.
package csrmv_pkg;

  localparam int MODE_W     = 3;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int VALUE_W    = 32;
  localparam int CFG_W      = 7;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int POS_W      = ROW_W + COL_W;
  localparam int VEC_DEPTH  = 64;
  localparam int FRAC_BITS  = 16;
  localparam int VALUE_BITS = 32;
  localparam int SUM_BITS   = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  localparam int MAX_ROWS_DEF     = 64;
  localparam int MAX_NONZEROS_DEF = 4096;

  localparam logic [CFG_W-1:0] ROW_COUNT_RST = 7'd64;
  localparam logic [CFG_W-1:0] COL_COUNT_RST = 7'd64;

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRODUCT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd2;

  localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_ORDER = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 3'd0,
    MODE_LOAD   = 3'd1,
    MODE_VECTOR = 3'd2,
    MODE_LOOKUP = 3'd3,
    MODE_MULT   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_INFO,
    S_NZ,
    S_VEC,
    S_ACC,
    S_ROW_END
  } state_t;

endpackage

[rtl/csrmv_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on csrmv_pkg for default sizes.
module csrmv_ram
  import csrmv_pkg::*;
#(
  parameter int WIDTH = VALUE_W,
  parameter int DEPTH = VEC_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sparse_csr_matrix_vector_multiply.sv]
`timescale 1ns / 1ps
// Top level of the CSR sparse matrix-vector multiplier: command decode, row walker,
// multiply-accumulate and result register. Depends on csrmv_pkg and csrmv_ram.
//
//  channel  | signals                          | direction | payload
//  ---------+----------------------------------+-----------+---------------------------------
//  command  | cmd_valid / cmd_stall            | in        | mode, row, col, value
//  response | rsp_valid / rsp_stall            | out       | kind, row_res, result, last,
//           |                                  |           | saturated, status
//  config   | cfg_we, cfg_index, cfg_data      | in        | row_count (0), col_count (1)
//
// Clear, nonzero load and vector load complete in the cycle they are accepted; a new command follows at once,
// unless a load status finds the response register stalled, which holds off the input.
// An in-range lookup reads the row info, then scans the row's nonzeros until a column hit or
// the row end, then answers; an out-of-range lookup answers straight from idle.
// Multiply walks every row in turn: each nonzero costs a column/value RAM read, a vector
// RAM read and a multiply, in series, and then an accumulate.
// Reset is synchronous; the row table and vector read as empty/zero through valid flags.
// A stalled response holds the walker in place; no clearing pass is needed.
module sparse_csr_matrix_vector_multiply
  import csrmv_pkg::*;
#(
  parameter int MAX_ROWS     = MAX_ROWS_DEF,
  parameter int MAX_NONZEROS = MAX_NONZEROS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  logic [MODE_W-1:0]          mode,
  input  logic [ROW_W-1:0]           row,
  input  logic [COL_W-1:0]           col,
  input  logic signed [VALUE_W-1:0]  value,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [KIND_W-1:0]          kind,
  output logic [ROW_W-1:0]           row_res,
  output logic signed [VALUE_W-1:0]  result,
  output logic                       last,
  output logic                       saturated,
  output logic [STATUS_W-1:0]        status
);

  localparam int RAW    = $clog2(MAX_ROWS);
  localparam int NZ_AW  = $clog2(MAX_NONZEROS);
  localparam int NZ_CW  = $clog2(MAX_NONZEROS + 1);
  localparam int INFO_W = 2 * NZ_CW;
  localparam int NZ_W   = COL_W + VALUE_W;
  localparam int VEC_AW = $clog2(VEC_DEPTH);
  localparam int PROD_W = 2 * VALUE_W;
  localparam int RND_W  = PROD_W - FRAC_BITS;
  localparam int ACC_W  = RND_W + NZ_CW;

  localparam logic signed [ACC_W-1:0] SUM_HI =
    {{(ACC_W - SUM_BITS + 1){1'b0}}, {(SUM_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SUM_LO =
    {{(ACC_W - SUM_BITS + 1){1'b1}}, {(SUM_BITS - 1){1'b0}}};
  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  state_t state, state_next;

  // control state
  logic [CFG_W-1:0]     row_count, col_count;
  logic [NZ_CW-1:0]     nz_count;
  logic [POS_W-1:0]     last_position;
  logic [RAW-1:0]       last_row;
  logic [NZ_CW-1:0]     cur_first;
  logic [MAX_ROWS-1:0]  info_valid;
  logic [VEC_DEPTH-1:0] vec_valid;

  // walker and datapath
  logic [RAW-1:0]              wrow, wrow_next;
  logic [NZ_CW-1:0]            idx, idx_next;
  logic [NZ_CW-1:0]            row_end_idx;
  logic                        op_mult;
  logic [COL_W-1:0]            lk_col;
  logic signed [VALUE_W-1:0]   hit_val;
  logic signed [VALUE_W-1:0]   mval;
  logic [COL_W-1:0]            vcol;
  logic                        mcol_ok;
  logic signed [PROD_W-1:0]    prod;
  logic signed [ACC_W-1:0]     acc;
  logic [KIND_W-1:0]           pend_kind;
  logic [ROW_W-1:0]            pend_row;
  logic [STATUS_W-1:0]         pend_status;

  // decode
  logic                  cmd_acc, can_emit;
  logic [CFG_W-1:0]      nrows, ncols;
  logic                  ld_order_bad, ld_full, ld_write, lk_in;
  logic [STATUS_W-1:0]   ld_status;
  logic [NZ_CW-1:0]      ld_first;
  logic                  info_empty, elem_last, col_hit, row_last;
  logic [NZ_CW-1:0]      info_first, info_end;
  logic [COL_W-1:0]      nz_rcol;
  logic signed [VALUE_W-1:0] nz_rval, vec_op;
  logic signed [PROD_W-1:0]  prod_rnd;
  logic signed [ACC_W-1:0]   rnd_ext;

  // emit
  logic                        emit;
  logic [KIND_W-1:0]           em_kind;
  logic [ROW_W-1:0]            em_row;
  logic signed [VALUE_W-1:0]   em_result;
  logic                        em_last, em_sat;
  logic [STATUS_W-1:0]         em_status;

  // memories
  logic              nz_we, info_we, vec_we;
  logic [NZ_W-1:0]   nz_rdata;
  logic [INFO_W-1:0] info_rdata;
  logic [VALUE_W-1:0] vec_rdata;

  csrmv_ram #(.WIDTH(NZ_W), .DEPTH(MAX_NONZEROS)) u_nz_ram (
    .clk   (clk),
    .we    (nz_we),
    .waddr (nz_count[NZ_AW-1:0]),
    .wdata ({col, value}),
    .raddr (idx_next[NZ_AW-1:0]),
    .rdata (nz_rdata)
  );

  csrmv_ram #(.WIDTH(INFO_W), .DEPTH(MAX_ROWS)) u_info_ram (
    .clk   (clk),
    .we    (info_we),
    .waddr (row[RAW-1:0]),
    .wdata ({ld_first, nz_count + NZ_CW'(1)}),
    .raddr (wrow_next),
    .rdata (info_rdata)
  );

  csrmv_ram #(.WIDTH(VALUE_W), .DEPTH(VEC_DEPTH)) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (col[VEC_AW-1:0]),
    .wdata (value),
    .raddr (nz_rcol[VEC_AW-1:0]),
    .rdata (vec_rdata)
  );

  assign cmd_stall = (state != S_IDLE);
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign can_emit  = !rsp_valid || !rsp_stall;

  always_comb begin
    if (row_count == '0) begin
      nrows = CFG_W'(1);
    end else if (row_count > CFG_W'(MAX_ROWS)) begin
      nrows = CFG_W'(MAX_ROWS);
    end else begin
      nrows = row_count;
    end
    ncols = (col_count > CFG_W'(VEC_DEPTH)) ? CFG_W'(VEC_DEPTH) : col_count;

    ld_order_bad = (CFG_W'(row) >= nrows) || (CFG_W'(col) >= ncols) ||
                   ((nz_count != '0) && ({row, col} <= last_position));
    ld_full      = (nz_count >= NZ_CW'(MAX_NONZEROS));
    ld_write     = (value != '0) && !ld_order_bad && !ld_full;
    if (value == '0) begin
      ld_status = STS_OK;
    end else if (ld_order_bad) begin
      ld_status = STS_ORDER;
    end else if (ld_full) begin
      ld_status = STS_FULL;
    end else begin
      ld_status = STS_OK;
    end
    ld_first = ((nz_count != '0) && (row[RAW-1:0] == last_row)) ? cur_first : nz_count;
    lk_in    = (CFG_W'(row) < nrows) && (CFG_W'(col) < ncols);

    info_first = info_rdata[INFO_W-1:NZ_CW];
    info_end   = info_rdata[NZ_CW-1:0];
    info_empty = !info_valid[wrow];
    nz_rcol    = nz_rdata[NZ_W-1 -: COL_W];
    nz_rval    = nz_rdata[VALUE_W-1:0];
    col_hit    = (nz_rcol == lk_col);
    elem_last  = (idx + NZ_CW'(1) == row_end_idx);
    row_last   = (CFG_W'(wrow) + CFG_W'(1) == nrows);

    vec_op   = (mcol_ok && vec_valid[vcol[VEC_AW-1:0]]) ? vec_rdata : '0;
    prod_rnd = prod + RND_HALF;
    rnd_ext  = {{(ACC_W - RND_W){prod_rnd[PROD_W-1]}}, prod_rnd[PROD_W-1:FRAC_BITS]};
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_acc) begin
          case (mode)
            MODE_LOAD:   state_next = can_emit ? S_IDLE : S_EMIT;
            MODE_LOOKUP: state_next = lk_in ? S_INFO : (can_emit ? S_IDLE : S_EMIT);
            MODE_MULT:   state_next = S_INFO;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_EMIT:    state_next = can_emit ? S_IDLE : S_EMIT;
      S_INFO:    state_next = info_empty ? S_ROW_END : S_NZ;
      S_NZ: begin
        if (op_mult) begin
          state_next = S_VEC;
        end else if (col_hit || elem_last) begin
          state_next = S_ROW_END;
        end
      end
      S_VEC:     state_next = S_ACC;
      S_ACC:     state_next = elem_last ? S_ROW_END : S_NZ;
      S_ROW_END: begin
        if (can_emit) begin
          state_next = (op_mult && !row_last) ? S_INFO : S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    em_kind   = KIND_LOOKUP;
    em_row    = row;
    em_result = '0;
    em_last   = 1'b0;
    em_sat    = 1'b0;
    em_status = STS_OK;
    nz_we     = 1'b0;
    info_we   = 1'b0;
    vec_we    = 1'b0;
    wrow_next = wrow;
    idx_next  = idx;
    case (state)
      S_IDLE: begin
        if (cmd_acc) begin
          case (mode)
            MODE_LOAD: begin
              emit      = can_emit;
              em_kind   = KIND_STATUS;
              em_status = ld_status;
              nz_we     = ld_write;
              info_we   = ld_write;
            end
            MODE_VECTOR: vec_we = (CFG_W'(col) < ncols);
            MODE_LOOKUP: begin
              if (lk_in) begin
                wrow_next = row[RAW-1:0];
              end else begin
                emit = can_emit;
              end
            end
            MODE_MULT: wrow_next = '0;
            default: ;
          endcase
        end
      end
      S_EMIT: begin
        emit      = can_emit;
        em_kind   = pend_kind;
        em_row    = pend_row;
        em_status = pend_status;
      end
      S_INFO: idx_next = info_first;
      S_NZ: begin
        if (!op_mult && !col_hit && !elem_last) begin
          idx_next = idx + NZ_CW'(1);
        end
      end
      S_ACC: begin
        if (!elem_last) begin
          idx_next = idx + NZ_CW'(1);
        end
      end
      S_ROW_END: begin
        emit   = can_emit;
        em_row = ROW_W'(wrow);
        if (op_mult) begin
          em_kind = KIND_PRODUCT;
          em_last = row_last;
          if (acc > SUM_HI) begin
            em_result = SUM_HI[VALUE_W-1:0];
            em_sat    = 1'b1;
          end else if (acc < SUM_LO) begin
            em_result = SUM_LO[VALUE_W-1:0];
            em_sat    = 1'b1;
          end else begin
            em_result = acc[VALUE_W-1:0];
          end
          if (can_emit && !row_last) begin
            wrow_next = wrow + RAW'(1);
          end
        end else begin
          em_result = hit_val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      row_count     <= ROW_COUNT_RST;
      col_count     <= COL_COUNT_RST;
      nz_count      <= '0;
      last_position <= '0;
      info_valid    <= '0;
      vec_valid     <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_COUNT: row_count <= cfg_data;
          REG_COL_COUNT: col_count <= cfg_data;
          default: ;
        endcase
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cmd_acc && (mode == MODE_CLEAR)) begin
        nz_count      <= '0;
        last_position <= '0;
        info_valid    <= '0;
      end
      if (nz_we) begin
        nz_count              <= nz_count + NZ_CW'(1);
        last_position         <= {row, col};
        info_valid[row[RAW-1:0]] <= 1'b1;
      end
      if (vec_we) begin
        vec_valid[col[VEC_AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    wrow <= wrow_next;
    idx  <= idx_next;
    if (emit) begin
      kind      <= em_kind;
      row_res   <= em_row;
      result    <= em_result;
      last      <= em_last;
      saturated <= em_sat;
      status    <= em_status;
    end
    if (nz_we) begin
      last_row  <= row[RAW-1:0];
      cur_first <= ld_first;
    end
    case (state)
      S_IDLE: begin
        if (cmd_acc) begin
          lk_col      <= col;
          op_mult     <= (mode == MODE_MULT);
          pend_row    <= row;
          pend_kind   <= (mode == MODE_LOAD) ? KIND_STATUS : KIND_LOOKUP;
          pend_status <= (mode == MODE_LOAD) ? ld_status : STS_OK;
        end
      end
      S_INFO: begin
        acc         <= '0;
        hit_val     <= '0;
        row_end_idx <= info_end;
      end
      S_NZ: begin
        mval    <= nz_rval;
        vcol    <= nz_rcol;
        mcol_ok <= (CFG_W'(nz_rcol) < ncols);
        if (!op_mult && col_hit) begin
          hit_val <= nz_rval;
        end
      end
      S_VEC:   prod <= mval * vec_op;
      S_ACC:   acc <= acc + rnd_ext;
      default: ;
    endcase
  end

  a_nz_bound: assert property (@(posedge clk) disable iff (rst)
    nz_count <= NZ_CW'(MAX_NONZEROS))
    else $error("nonzero count beyond capacity");

  a_walk_in_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_NZ || state == S_ACC) |-> (idx < row_end_idx))
    else $error("walker left the row range");

  a_mult_start: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && mode == MODE_MULT) |=> (state == S_INFO && wrow == '0))
    else $error("multiply did not start at row zero");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> !emit)
    else $error("pending response overwritten");

endmodule
